/* sv/at_response_frame_detector_top_macros.svh */
// Assertion macros for the modem response frame detector.
`ifndef AT_RESPONSE_FRAME_DETECTOR_TOP_MACROS_SVH
`define AT_RESPONSE_FRAME_DETECTOR_TOP_MACROS_SVH
`ifndef SYNTHESIS
`define AFD_ASSERT(lbl, clk, rstn, prop) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (prop)) \
    else $error("frame detector check failed");
`define AFD_ASSERT_NEXT(lbl, clk, rstn, cond, expr) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (cond) |=> (expr)) \
    else $error("frame detector next-cycle check failed");
`else
`define AFD_ASSERT(lbl, clk, rstn, prop)
`define AFD_ASSERT_NEXT(lbl, clk, rstn, cond, expr)
`endif
`endif

/* sv/afd_pkg.sv */
// Shared types, constants and terminator patterns of the frame detector.
`default_nettype none
package afd_pkg;

  localparam int unsigned FRAME_DEPTH = 1024;
  localparam int unsigned CNT_W       = $clog2(FRAME_DEPTH);
  localparam int unsigned HIST_LEN    = 8;
  localparam int unsigned WIN_LEN     = HIST_LEN + 1;

  typedef enum logic [1:0] {
    CMD_ARM  = 2'd0,
    CMD_BYTE = 2'd1,
    CMD_READ = 2'd2
  } cmd_e;

  typedef enum logic [1:0] {
    RES_FAIL  = 2'd0,
    RES_OK    = 2'd1,
    RES_ERROR = 2'd2
  } result_e;

  // window position 0 is the oldest byte, position WIN_LEN-1 the newest
  localparam logic [WIN_LEN-1:0][7:0] OK_PAT = {
    8'h0A, 8'h0D, 8'h4B, 8'h4F, 8'h0A, 8'h0D, 8'h00, 8'h00, 8'h00
  };
  localparam logic [WIN_LEN-1:0] OK_CARE = 9'b111111000;
  localparam logic [WIN_LEN-1:0][7:0] ERR_PAT = {
    8'h0A, 8'h0D, 8'h52, 8'h4F, 8'h52, 8'h52, 8'h45, 8'h0A, 8'h0D
  };

  typedef struct packed {
    logic [1:0] command;
    logic [7:0] byte_value;
    logic [9:0] read_index;
  } in_word_t;

  typedef struct packed {
    logic [1:0] result_code;
    logic       receiving;
    logic [9:0] byte_count;
    logic [7:0] read_data;
  } out_word_t;

  typedef struct packed {
    logic shift;
    logic clear;
  } win_ctl_t;

  typedef struct packed {
    logic ok_match;
    logic err_match;
  } win_hit_t;

endpackage
`default_nettype wire

/* sv/at_response_frame_detector_top.sv */
// Modem response frame detector top level: control, frame store, output register.
//
// Input channel carries command words (arm, received byte, read); output channel
// returns one status word per input word: result code, receiving flag, byte count
// and read data. Both channels use valid/stall; a word moves when valid is high
// and stall is low.
// The status word is registered and presented in the cycle after its input word is taken.
// One word is taken per cycle unless the output is stalled; the single-port frame
// store with its registered read and the eight-cell history chain keep up with it.
// An arm clears count, history and zero-byte flag and sets the result to fail.
// Reset clears all control state and the history cells; the frame store is not
// cleared, since reads at or beyond the count return zero.
// While the output word is stalled it holds, and the input is stalled too; once
// the output stall drops, input words are taken again in the same cycle.
`default_nettype none
`include "at_response_frame_detector_top_macros.svh"
module at_response_frame_detector_top (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               in_stall_o,
  input  afd_pkg::in_word_t  in_word_i,
  output logic               out_valid_o,
  input  logic               out_stall_i,
  output afd_pkg::out_word_t out_word_o
);

  localparam int unsigned CNT_W = afd_pkg::CNT_W;
  localparam logic [CNT_W-1:0] CNT_FULL = CNT_W'(afd_pkg::FRAME_DEPTH - 1);

  logic              in_accept;
  logic [CNT_W-1:0]  count_q, count_d;
  logic              armed_q, armed_d;
  afd_pkg::result_e  result_q, result_d;
  logic              zero_q, zero_d;
  afd_pkg::win_ctl_t win_ctl;
  afd_pkg::win_hit_t win_hit;
  logic              mem_we;
  logic              rd_en;
  logic              rd_hit_d;
  logic [CNT_W-1:0]  rd_addr;

  logic              out_valid_q;
  afd_pkg::result_e  res_out_q;
  logic              recv_out_q;
  logic [CNT_W-1:0]  cnt_out_q;
  logic              rd_hit_q;
  logic [7:0]        rd_data_q;

  logic [7:0]        frame_mem [afd_pkg::FRAME_DEPTH];

  assign in_stall_o = out_valid_q && out_stall_i;
  assign in_accept  = in_valid_i && !in_stall_o;
  assign rd_addr    = CNT_W'(in_word_i.read_index);

  afd_window u_window (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .ctl_i  (win_ctl),
    .byte_i (in_word_i.byte_value),
    .hit_o  (win_hit)
  );

  always_comb begin
    count_d  = count_q;
    armed_d  = armed_q;
    result_d = result_q;
    zero_d   = zero_q;
    win_ctl  = '0;
    mem_we   = 1'b0;
    rd_en    = 1'b0;
    rd_hit_d = 1'b0;
    if (in_accept) begin
      unique case (in_word_i.command)
        afd_pkg::CMD_ARM: begin
          count_d       = '0;
          armed_d       = 1'b1;
          result_d      = afd_pkg::RES_FAIL;
          zero_d        = 1'b0;
          win_ctl.clear = 1'b1;
        end
        afd_pkg::CMD_BYTE: begin
          if (armed_q) begin
            if (count_q == CNT_FULL) begin
              result_d = afd_pkg::RES_FAIL;
              armed_d  = 1'b0;
            end else begin
              mem_we        = 1'b1;
              count_d       = count_q + 1'b1;
              zero_d        = zero_q || (in_word_i.byte_value == 8'h00);
              win_ctl.shift = 1'b1;
              if (!zero_d) begin
                if (win_hit.ok_match) begin
                  result_d = afd_pkg::RES_OK;
                  armed_d  = 1'b0;
                end else if (win_hit.err_match) begin
                  result_d = afd_pkg::RES_ERROR;
                  armed_d  = 1'b0;
                end
              end
            end
          end
        end
        afd_pkg::CMD_READ: begin
          rd_en    = 1'b1;
          rd_hit_d = 32'(in_word_i.read_index) < 32'(count_q);
        end
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q     <= '0;
      armed_q     <= 1'b0;
      result_q    <= afd_pkg::RES_FAIL;
      zero_q      <= 1'b0;
      out_valid_q <= 1'b0;
      rd_hit_q    <= 1'b0;
    end else begin
      count_q  <= count_d;
      armed_q  <= armed_d;
      result_q <= result_d;
      zero_q   <= zero_d;
      if (in_accept) begin
        out_valid_q <= 1'b1;
        rd_hit_q    <= rd_hit_d;
      end else if (!out_stall_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_accept) begin
      res_out_q  <= result_d;
      recv_out_q <= armed_d;
      cnt_out_q  <= count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      frame_mem[count_q] <= in_word_i.byte_value;
    end
    if (rd_en) begin
      rd_data_q <= frame_mem[rd_addr];
    end
  end

  assign out_valid_o            = out_valid_q;
  assign out_word_o.result_code = res_out_q;
  assign out_word_o.receiving   = recv_out_q;
  assign out_word_o.byte_count  = 10'(cnt_out_q);
  assign out_word_o.read_data   = rd_hit_q ? rd_data_q : 8'h00;

  `AFD_ASSERT(a_hold_input_on_stall, clk_i, rst_ni, (out_valid_q && out_stall_i) |-> !in_accept)
  `AFD_ASSERT(a_armed_means_fail, clk_i, rst_ni, armed_q |-> (result_q == afd_pkg::RES_FAIL))
  `AFD_ASSERT(a_count_in_range, clk_i, rst_ni, count_q <= CNT_FULL)
  `AFD_ASSERT_NEXT(a_full_stops, clk_i, rst_ni, in_accept && (in_word_i.command == afd_pkg::CMD_BYTE) && (count_q == CNT_FULL), !armed_q && (count_q == CNT_FULL))

endmodule
`default_nettype wire

/* sv/afd_cell.sv */
// One history cell: holds a byte, passes it on, compares it to its pattern bytes.
`default_nettype none
module afd_cell (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  afd_pkg::win_ctl_t ctl_i,
  input  logic [7:0]       byte_i,
  input  logic [7:0]       ok_pat_i,
  input  logic             ok_care_i,
  input  logic [7:0]       err_pat_i,
  output logic [7:0]       byte_o,
  output logic             ok_hit_o,
  output logic             err_hit_o
);

  logic [7:0] byte_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      byte_q <= '0;
    end else if (ctl_i.clear) begin
      byte_q <= '0;
    end else if (ctl_i.shift) begin
      byte_q <= byte_i;
    end
  end

  assign byte_o    = byte_q;
  assign ok_hit_o  = !ok_care_i || (byte_q == ok_pat_i);
  assign err_hit_o = (byte_q == err_pat_i);

endmodule
`default_nettype wire

/* sv/afd_window.sv */
// Chain of history cells and the terminator match over the newest bytes.
`default_nettype none
module afd_window (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  afd_pkg::win_ctl_t ctl_i,
  input  logic [7:0]        byte_i,
  output afd_pkg::win_hit_t hit_o
);

  logic [afd_pkg::HIST_LEN-1:0][7:0] hist;
  logic [afd_pkg::HIST_LEN-1:0]      ok_hit;
  logic [afd_pkg::HIST_LEN-1:0]      err_hit;

  for (genvar k = 0; k < afd_pkg::HIST_LEN; k++) begin : g_cell
    logic [7:0] feed;
    if (k == afd_pkg::HIST_LEN - 1) begin : g_head
      assign feed = byte_i;
    end else begin : g_link
      assign feed = hist[k+1];
    end
    afd_cell u_cell (
      .clk_i     (clk_i),
      .rst_ni    (rst_ni),
      .ctl_i     (ctl_i),
      .byte_i    (feed),
      .ok_pat_i  (afd_pkg::OK_PAT[k]),
      .ok_care_i (afd_pkg::OK_CARE[k]),
      .err_pat_i (afd_pkg::ERR_PAT[k]),
      .byte_o    (hist[k]),
      .ok_hit_o  (ok_hit[k]),
      .err_hit_o (err_hit[k])
    );
  end

  assign hit_o.ok_match  = (&ok_hit) &&
                           (byte_i == afd_pkg::OK_PAT[afd_pkg::WIN_LEN-1]);
  assign hit_o.err_match = (&err_hit) &&
                           (byte_i == afd_pkg::ERR_PAT[afd_pkg::WIN_LEN-1]);

endmodule
`default_nettype wire
